// ===== sv/sife_pkg.sv =====
// Shared types, constants and marker tables for the stream id field extractor.
// Used by sife_front, sife_queue, sife_back and stream_id_field_extractor.
package sife_pkg;

  // Connection number width kept from the input
  localparam int CONN_BITS = 16;

  // Port payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 80;
  localparam int CONN_OUT_W  = 16;

  // Marker lengths
  localparam int MARK_MAX = 28;
  localparam int LEN_A    = 26;
  localparam int LEN_B    = 28;
  localparam int LEN_P    = 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Parse phases
  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Saturation bounds
  localparam logic [35:0] MAG_LIMIT_W = 36'h080000000;
  localparam logic [31:0] MAG_LIMIT   = 32'h80000000;
  localparam logic [31:0] POS_MAX     = 32'h7FFFFFFF;

  typedef logic [CONN_BITS-1:0] conn_t;
  typedef logic [4:0] mlen_t;
  typedef logic [1:0] phase_t;
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QCNT_W-1:0] qcnt_t;
  typedef logic [MARK_MAX-1:0][7:0] mark_t;
  typedef logic [MARK_MAX-1:0][MARK_MAX:0] border_t;

  // One classified stream word
  typedef struct packed {
    logic       is_nl;
    logic       is_blank;
    logic       is_minus;
    logic       is_plus;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] data;
    conn_t      conn;
  } item_t;

  // Back-end state seen by the top level
  typedef struct packed {
    phase_t phase;
    mlen_t  match_first;
    mlen_t  match_second;
    logic   simple_mode;
  } back_status_t;

  // Unpack a string literal into byte order, first character at index 0
  function automatic mark_t to_mark(logic [8*MARK_MAX-1:0] s, int len);
    mark_t m;
    int    i;
    m = '0;
    for (i = 0; i < len; i++) begin
      m[i] = s[8*(len-1-i) +: 8];
    end
    return m;
  endfunction

  // b[q][k]: first k-1 marker bytes equal the last k-1 of the q matched bytes
  function automatic border_t make_border(mark_t m, int len);
    border_t b;
    int      q;
    int      k;
    int      i;
    logic    ok;
    b = '0;
    for (q = 0; q < len; q++) begin
      for (k = 1; k <= q + 1; k++) begin
        ok = 1'b1;
        for (i = 0; i + 1 < k; i++) begin
          if (m[i] != m[q-k+1+i]) begin
            ok = 1'b0;
          end
        end
        b[q][k] = ok;
      end
    end
    return b;
  endfunction

  // Next matched length: longest candidate whose border fits and whose byte matches
  function automatic mlen_t kmp_next(mark_t m, int len, border_t b, mlen_t q,
                                     logic [7:0] c);
    mlen_t qq;
    mlen_t nxt;
    int    k;
    qq  = (int'(q) >= len) ? '0 : q;
    nxt = '0;
    for (k = 1; k <= MARK_MAX; k++) begin
      if ((k <= len) && (k <= int'(qq) + 1) && b[qq][k] && (m[k-1] == c)) begin
        nxt = mlen_t'(k);
      end
    end
    return nxt;
  endfunction

  localparam mark_t MARK_A = to_mark("\n{\nname: \"kn_id\",\nvalue: \"", LEN_A);
  localparam mark_t MARK_B = to_mark("\n{\nname : \"kn_id\",\nvalue : \"", LEN_B);
  localparam mark_t MARK_P = to_mark("\nkn_id: ", LEN_P);

  localparam border_t BORDER_A = make_border(MARK_A, LEN_A);
  localparam border_t BORDER_B = make_border(MARK_B, LEN_B);
  localparam border_t BORDER_P = make_border(MARK_P, LEN_P);

endpackage

// ===== sv/sife_front.sv =====
// Front end: classifies each incoming stream word for the parser.
// Depends on sife_pkg.
module sife_front (
  input  logic [sife_pkg::IN_TDATA_W-1:0] s_tdata, // data_byte[7:0], conn_id[23:8]
  output sife_pkg::item_t                 item
);

  logic [7:0]  data_byte;
  logic [15:0] conn_id;
  logic [7:0]  digit_off;

  assign data_byte = s_tdata[7:0];
  assign conn_id   = s_tdata[23:8];
  assign digit_off = data_byte - sife_pkg::CH_ZERO;

  // Classify the byte
  always_comb begin
    item.is_nl    = (data_byte == sife_pkg::CH_NL);
    item.is_blank = (data_byte == sife_pkg::CH_SPACE) || (data_byte == sife_pkg::CH_TAB);
    item.is_minus = (data_byte == sife_pkg::CH_MINUS);
    item.is_plus  = (data_byte == sife_pkg::CH_PLUS);
    item.is_digit = (data_byte >= sife_pkg::CH_ZERO) && (data_byte <= sife_pkg::CH_NINE);
    item.digit    = digit_off[3:0];
    item.data     = data_byte;
    item.conn     = sife_pkg::conn_t'(conn_id);
  end

endmodule

// ===== sv/sife_queue.sv =====
// Short queue of classified words between the front and back ends.
// Depends on sife_pkg.
module sife_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sife_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output sife_pkg::item_t head_item
);

  sife_pkg::item_t mem [sife_pkg::QUEUE_DEPTH];
  sife_pkg::qptr_t wr_ptr;
  sife_pkg::qptr_t rd_ptr;
  sife_pkg::qcnt_t count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == sife_pkg::qcnt_t'(sife_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == sife_pkg::qptr_t'(sife_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sife_pkg::qptr_t'(sife_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== sv/sife_back.sv =====
// Back end: marker matchers, atoi-style parser, byte counter and result register.
// Depends on sife_pkg.
module sife_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             head_valid,
  input  sife_pkg::item_t                  head_item,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sife_pkg::OUT_TDATA_W-1:0] m_tdata, // id_value[31:0], byte_total[63:32],
                                                    // conn_out[79:64]
  output sife_pkg::back_status_t           status
);

  logic             simple_mode;
  sife_pkg::phase_t phase;
  sife_pkg::phase_t phase_next;
  sife_pkg::mlen_t  match_first;
  sife_pkg::mlen_t  match_first_next;
  sife_pkg::mlen_t  match_second;
  sife_pkg::mlen_t  match_second_next;
  logic [31:0]      accum;
  logic [31:0]      accum_next;
  logic             negative;
  logic             negative_next;
  logic [31:0]      byte_counter;
  logic [31:0]      byte_counter_next;
  logic             emit;
  logic [31:0]      id_word;
  logic [35:0]      prod;
  logic [31:0]      sat;
  sife_pkg::mlen_t  adv_a;
  sife_pkg::mlen_t  adv_b;
  sife_pkg::mlen_t  adv_p;
  logic             hit;

  // Take a word when the result slot is free or draining
  assign pop = head_valid && (!m_tvalid || m_tready);

  assign status.phase        = phase;
  assign status.match_first  = match_first;
  assign status.match_second = match_second;
  assign status.simple_mode  = simple_mode;

  // Matcher steps for each marker
  always_comb begin
    adv_a = sife_pkg::kmp_next(sife_pkg::MARK_A, sife_pkg::LEN_A, sife_pkg::BORDER_A,
                               match_first, head_item.data);
    adv_b = sife_pkg::kmp_next(sife_pkg::MARK_B, sife_pkg::LEN_B, sife_pkg::BORDER_B,
                               match_second, head_item.data);
    adv_p = sife_pkg::kmp_next(sife_pkg::MARK_P, sife_pkg::LEN_P, sife_pkg::BORDER_P,
                               match_first, head_item.data);
  end

  // Accumulate one digit with saturation at 2^31
  always_comb begin
    prod = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + 36'(head_item.digit);
    sat  = (prod > sife_pkg::MAG_LIMIT_W) ? sife_pkg::MAG_LIMIT : prod[31:0];
  end

  // Final signed value, clamp positive overflow
  assign id_word = negative ? (32'd0 - accum)
                            : (accum[31] ? sife_pkg::POS_MAX : accum);

  // Next-state logic for one word
  always_comb begin
    phase_next        = phase;
    match_first_next  = match_first;
    match_second_next = match_second;
    accum_next        = accum;
    negative_next     = negative;
    byte_counter_next = byte_counter + 32'd1;
    emit              = 1'b0;
    hit               = 1'b0;
    case (phase)
      sife_pkg::PH_SEARCH: begin
        if (simple_mode) begin
          match_first_next  = adv_p;
          match_second_next = adv_p;
          hit = (adv_p == sife_pkg::mlen_t'(sife_pkg::LEN_P));
        end else begin
          match_first_next  = adv_a;
          match_second_next = adv_b;
          hit = (adv_a == sife_pkg::mlen_t'(sife_pkg::LEN_A)) ||
                (adv_b == sife_pkg::mlen_t'(sife_pkg::LEN_B));
        end
        if (hit) begin
          match_first_next  = '0;
          match_second_next = '0;
          phase_next        = sife_pkg::PH_SIGN;
          accum_next        = '0;
          negative_next     = 1'b0;
        end
      end
      default: begin
        if (head_item.is_nl) begin
          emit              = 1'b1;
          phase_next        = sife_pkg::PH_SEARCH;
          match_first_next  = '0;
          match_second_next = '0;
          accum_next        = '0;
          negative_next     = 1'b0;
        end else if (phase == sife_pkg::PH_SIGN && head_item.is_blank) begin
          phase_next = sife_pkg::PH_SIGN;
        end else if (phase == sife_pkg::PH_SIGN && (head_item.is_minus || head_item.is_plus)) begin
          negative_next = head_item.is_minus;
          phase_next    = sife_pkg::PH_DIGITS;
        end else if (phase == sife_pkg::PH_SIGN || phase == sife_pkg::PH_DIGITS) begin
          if (head_item.is_digit) begin
            accum_next = sat;
            phase_next = sife_pkg::PH_DIGITS;
          end else begin
            phase_next = sife_pkg::PH_DONE;
          end
        end
      end
    endcase
  end

  // Parser state and mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      simple_mode  <= 1'b0;
      phase        <= sife_pkg::PH_SEARCH;
      match_first  <= '0;
      match_second <= '0;
      accum        <= '0;
      negative     <= 1'b0;
      byte_counter <= '0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        match_first  <= match_first_next;
        match_second <= match_second_next;
        accum        <= accum_next;
        negative     <= negative_next;
        byte_counter <= byte_counter_next;
      end
      if (cfg_we) begin
        simple_mode  <= cfg_wdata;
        match_first  <= '0;
        match_second <= '0;
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      m_tdata <= {sife_pkg::CONN_OUT_W'(head_item.conn), byte_counter_next, id_word};
    end
  end

endmodule

// ===== sv/stream_id_field_extractor.sv =====
// Top level: front classifier, word queue and back-end parser.
// Path: an accepted word is stored in the queue, then the back end consumes it and registers the result.
// Throughput: one byte per cycle while the result slot is free or draining; the matcher and digit
// accumulator in the back end are combinational; the two-entry queue buffers words during output stalls.
// Reset: rst is synchronous and clears mode, matchers, parser state and counter.
module stream_id_field_extractor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,  // simple_mode
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sife_pkg::IN_TDATA_W-1:0]  s_tdata,    // data_byte[7:0], conn_id[23:8]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sife_pkg::OUT_TDATA_W-1:0] m_tdata     // id_value[31:0], byte_total[63:32],
                                                       // conn_out[79:64]
);

  sife_pkg::item_t        in_item;
  sife_pkg::item_t        head_item;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  sife_pkg::back_status_t st;

  assign s_tready = !q_full;

  sife_front u_front (
    .s_tdata (s_tdata),
    .item    (in_item)
  );

  sife_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_item  (in_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  sife_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (q_valid),
    .head_item  (head_item),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .status     (st)
  );

  // Simple mode drives both matchers identically
  a_simple_pair: assert property (@(posedge clk) disable iff (rst)
    st.simple_mode |-> (st.match_first == st.match_second))
    else $error("matchers diverge in simple mode");

  // Matchers rest at zero while a value is being parsed
  a_parse_idle: assert property (@(posedge clk) disable iff (rst)
    (st.phase != sife_pkg::PH_SEARCH) |->
      (st.match_first == '0 && st.match_second == '0))
    else $error("matcher active outside search");

  // A result appears only after the back end took a word
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(q_pop))
    else $error("result without consumed word");

  // Stored match length stays below the longest marker
  a_match_range: assert property (@(posedge clk) disable iff (rst)
    (st.match_first < sife_pkg::mlen_t'(sife_pkg::LEN_B)) &&
    (st.match_second < sife_pkg::mlen_t'(sife_pkg::LEN_B)))
    else $error("match length out of range");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for stream_id_field_extractor: byte streams with id markers in both modes.
// Depends on sife_pkg (phase and character codes, conn_t) and on the top level RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT  = 200000;  // cycle budget for the whole run
  localparam int SETTLE = 8;       // cycles to let the pipeline empty before a mode write
  localparam int MIN_BYTES   = 1100;
  localparam int MIN_REPORTS = 32;

  localparam string MARK_ONE   = "\n{\nname: \"kn_id\",\nvalue: \"";
  localparam string MARK_TWO   = "\n{\nname : \"kn_id\",\nvalue : \"";
  localparam string MARK_PLAIN = "\nkn_id: ";

  // One stream word as it sits on s_tdata
  typedef struct packed {
    sife_pkg::conn_t conn;
    logic [7:0]      data;
  } stream_word_t;

  // One id report as it sits on m_tdata
  typedef struct packed {
    sife_pkg::conn_t conn;
    logic [31:0]     total;
    logic [31:0]     id;
  } id_report_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic                             cfg_wdata;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [sife_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [sife_pkg::OUT_TDATA_W-1:0] m_tdata;

  stream_word_t bytes_to_send[$];
  id_report_t   ids_due[$];

  // Predictor copy of the parser state
  logic             mode_plain;
  int               hit_one;
  int               hit_two;
  sife_pkg::phase_t parse_phase;
  logic [31:0]      magnitude;
  logic             is_neg;
  logic [31:0]      bytes_seen;

  int  cycle;
  int  errors;
  int  words_in;
  int  ids_checked;
  int  mode_writes;
  int  queued_total;
  int  stall_left;
  bit  stall_used;
  bit  stall_req;
  bit  in_taken;
  bit  calm;

  stream_id_field_extractor uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 50 MHz clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Length of the longest marker prefix that ends the q matched bytes plus c
  function automatic int prefix_after(input string m, input int q, input logic [7:0] c);
    int  k;
    int  i;
    bit  ok;
    if (q >= m.len()) q = 0;
    for (k = q + 1; k >= 1; k--) begin
      ok = (8'(m[k-1]) == c);
      for (i = 0; ok && i + 1 < k; i++) begin
        if (m[i] != m[q-k+1+i]) ok = 1'b0;
      end
      if (ok) return k;
    end
    return 0;
  endfunction

  // Advance the predicted parser by one accepted byte; queue a report on a terminating newline
  task automatic track_byte(input logic [7:0] b, input sife_pkg::conn_t c);
    bit          found;
    logic [63:0] wide;
    id_report_t  rep;
    bytes_seen = bytes_seen + 32'd1;
    if (parse_phase == sife_pkg::PH_SEARCH) begin
      if (mode_plain) begin
        hit_one = prefix_after(MARK_PLAIN, hit_one, b);
        hit_two = hit_one;
        found   = (hit_one == MARK_PLAIN.len());
      end else begin
        hit_one = prefix_after(MARK_ONE, hit_one, b);
        hit_two = prefix_after(MARK_TWO, hit_two, b);
        found   = (hit_one == MARK_ONE.len()) || (hit_two == MARK_TWO.len());
      end
      if (found) begin
        hit_one     = 0;
        hit_two     = 0;
        parse_phase = sife_pkg::PH_SIGN;
        magnitude   = '0;
        is_neg      = 1'b0;
      end
      return;
    end
    // Newline closes the value in any parse phase
    if (b == sife_pkg::CH_NL) begin
      if (is_neg) rep.id = 32'd0 - magnitude;
      else rep.id = (magnitude >= sife_pkg::MAG_LIMIT) ? sife_pkg::POS_MAX : magnitude;
      rep.total = bytes_seen;
      rep.conn  = c;
      ids_due.push_back(rep);
      parse_phase = sife_pkg::PH_SEARCH;
      hit_one     = 0;
      hit_two     = 0;
      magnitude   = '0;
      is_neg      = 1'b0;
      return;
    end
    if (parse_phase == sife_pkg::PH_SIGN) begin
      if (b == sife_pkg::CH_SPACE || b == sife_pkg::CH_TAB) return;
      if (b == sife_pkg::CH_MINUS || b == sife_pkg::CH_PLUS) begin
        is_neg      = (b == sife_pkg::CH_MINUS);
        parse_phase = sife_pkg::PH_DIGITS;
        return;
      end
      parse_phase = sife_pkg::PH_DIGITS;
    end
    if (parse_phase == sife_pkg::PH_DIGITS) begin
      if (b >= sife_pkg::CH_ZERO && b <= sife_pkg::CH_NINE) begin
        wide      = {32'd0, magnitude} * 64'd10 + 64'(b - sife_pkg::CH_ZERO);
        magnitude = (wide > 64'(sife_pkg::MAG_LIMIT)) ? sife_pkg::MAG_LIMIT : wide[31:0];
      end else begin
        parse_phase = sife_pkg::PH_DONE;
      end
    end
  endtask

  // Check results, predict accepted words and mode writes
  always @(posedge clk) begin : observe
    id_report_t want;
    id_report_t got;
    in_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = id_report_t'(m_tdata);
        if (ids_due.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual id %0d total %0d conn %0h",
                   $time, $signed(got.id), got.total, got.conn);
          errors++;
        end else begin
          want = ids_due.pop_front();
          if (got.id !== want.id) begin
            $display("%0t: id_value mismatch: expected %0d, actual %0d",
                     $time, $signed(want.id), $signed(got.id));
            errors++;
          end
          if (got.total !== want.total) begin
            $display("%0t: byte_total mismatch: expected %0d, actual %0d",
                     $time, want.total, got.total);
            errors++;
          end
          if (got.conn !== want.conn) begin
            $display("%0t: conn_out mismatch: expected %0h, actual %0h",
                     $time, want.conn, got.conn);
            errors++;
          end
          ids_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        track_byte(s_tdata[7:0], s_tdata[23:8]);
        void'(bytes_to_send.pop_front());
        words_in++;
      end
      if (cfg_we) begin
        mode_plain = cfg_wdata;
        hit_one    = 0;
        hit_two    = 0;
      end
    end
  end

  // Drive the input stream from the pending queue, with random gaps
  always @(negedge clk) begin : drive
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= bytes_to_send[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Drive the output ready with random stalls and one long hold-off
  always @(negedge clk) begin : sink
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!stall_used && stall_req) begin
        stall_used = 1'b1;
        stall_left = 150;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // Count cycles, open a window with no idling, end a hung run
  always @(posedge clk) begin : watchdog
    cycle++;
    calm = (cycle >= 600 && cycle < 1400);
    if (cycle >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input sife_pkg::conn_t c);
    stream_word_t w;
    w.conn = c;
    w.data = b;
    bytes_to_send.push_back(w);
    queued_total++;
  endtask

  task automatic add_text(input string s, input sife_pkg::conn_t c);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(8'(s[i]), c);
  endtask

  // Wait until the stream has drained and every report is in, then let the block settle
  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || s_tvalid || ids_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic plain);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= plain;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    mode_writes++;
  endtask

  // One record: noise, a marker (sometimes cut short), a value with random shape, newline
  task automatic add_record(input logic plain);
    sife_pkg::conn_t c;
    string           m;
    int              n;
    int              i;
    int              r;
    logic [7:0]      b;
    c = sife_pkg::conn_t'($urandom);
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 5) : $urandom_range(3);
    for (i = 0; i < n; i++) add_byte(8'($urandom_range(255)), c);
    if (plain) m = MARK_PLAIN;
    else m = $urandom_range(1) ? MARK_TWO : MARK_ONE;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(m.len() - 1);
      for (i = 0; i < n; i++) add_byte(8'(m[i]), c);
      add_byte(8'($urandom_range(255)), c);
    end else begin
      add_text(m, c);
    end
    // leading blanks and sign
    n = $urandom_range(2);
    for (i = 0; i < n; i++) add_byte($urandom_range(1) ? sife_pkg::CH_SPACE : sife_pkg::CH_TAB, c);
    r = $urandom_range(5);
    if (r == 0) add_byte(sife_pkg::CH_MINUS, c);
    else if (r == 1) add_byte(sife_pkg::CH_PLUS, c);
    // digits: occasionally none, occasionally enough to saturate
    r = $urandom_range(19);
    if (r == 0) n = 0;
    else if (r <= 2) n = $urandom_range(14, 10);
    else n = $urandom_range(9, 1);
    for (i = 0; i < n; i++) add_byte(sife_pkg::CH_ZERO + 8'($urandom_range(9)), c);
    // trailing junk up to the newline
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) begin
        b = 8'($urandom_range(255));
        if (b == sife_pkg::CH_NL) b = 8'h0B;
        add_byte(b, c);
      end
    end
    add_byte(sife_pkg::CH_NL, c);
  endtask

  initial begin : stimulus
    logic cur_mode;
    int   records;
    int   rand_start;
    int   phase_start;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    mode_plain   = 1'b0;
    hit_one      = 0;
    hit_two      = 0;
    parse_phase  = sife_pkg::PH_SEARCH;
    magnitude    = '0;
    is_neg       = 1'b0;
    bytes_seen   = '0;
    cycle        = 0;
    errors       = 0;
    words_in     = 0;
    ids_checked  = 0;
    mode_writes  = 0;
    queued_total = 0;
    stall_left   = 0;
    stall_used   = 1'b0;
    stall_req    = 1'b0;
    in_taken     = 1'b0;
    calm         = 1'b0;
    records      = 0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Script markers straight after reset, connection extremes
    add_text({MARK_ONE, "42\"\n"}, 16'h0000);
    add_text({MARK_TWO, "\t-7\"\n"}, 16'hFFFF);
    wait_idle();

    // Plain marker: empty values, saturation, atoi stop rules
    write_mode(1'b1);
    add_text("\nkn_id: \n", 16'h0001);
    add_text("\nkn_id: \t +\n", 16'h8000);
    add_text("\nkn_id: 2147483648\n", 16'h00FF);
    add_text("\nkn_id: -2147483648\n", 16'hFF00);
    add_text("\nkn_id: -99999999999\n", 16'h5A5A);
    add_text("\nkn_id: - 5\n", 16'hA5A5);
    add_text("\nkn_id: \0157\n\nkn_id: \0138\n\nkn_id: \0149\n", 16'h1234);
    add_text("\nkn_id: 12x34\n", 16'h4321);
    // the newline ending a value must not start the next marker
    add_text("\nkn_id: 1\nkn_id: 2\n\nkn_id: 3\n", 16'h7FFF);
    add_byte(8'h00, 16'h0000);
    add_byte(8'hFF, 16'hFFFF);
    add_text("\nkn_id: 12", 16'h0F0F);
    wait_idle();

    // Mode write while a value is open, then while a marker is half matched
    write_mode(1'b0);
    add_text("34\n", 16'hF0F0);
    wait_idle();
    write_mode(1'b1);
    add_text("\nkn_i", 16'h0002);
    wait_idle();
    write_mode(1'b1);
    add_text("d: 5\n", 16'h0003);
    wait_idle();
    cur_mode = 1'b1;

    // Random phases, alternating the mode between them
    rand_start = queued_total;
    while (queued_total - rand_start < MIN_BYTES || records < MIN_REPORTS) begin
      cur_mode = !cur_mode;
      write_mode(cur_mode);
      phase_start = queued_total;
      while (queued_total - phase_start < 220) begin
        add_record(cur_mode);
        records++;
      end
      // hold off the receiver once while a full phase is still queued
      stall_req = 1'b1;
      wait_idle();
    end

    $display("Streamed %0d bytes through %0d mode writes, checked %0d id reports.",
             words_in, mode_writes, ids_checked);
    if (errors == 0 && ids_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
